[hdl/tsps_pkg.sv]
// Shared types and codes for the tracker song-position sequencer.
// No dependencies; imported by the top level.
`default_nettype none

package tsps_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_ROW_EFFECT = 2'd1,
        CMD_ROW_END    = 2'd2,
        CMD_GOTO       = 2'd3
    } command_t;

    // Row effect codes
    localparam logic [2:0] FX_SPEED       = 3'd0;
    localparam logic [2:0] FX_JUMP        = 3'd1;
    localparam logic [2:0] FX_BREAK       = 3'd2;
    localparam logic [2:0] FX_LOOP_START  = 3'd3;
    localparam logic [2:0] FX_LOOP        = 3'd4;
    localparam logic [2:0] FX_PATT_DELAY  = 3'd5;

    // Reset values
    localparam logic [7:0] TICKS_PER_ROW_RESET = 8'd6;
    localparam logic [7:0] TICK_LEFT_RESET     = 8'd1;
    localparam logic [8:0] TRACK_LENGTH_RESET  = 9'd1;
    localparam int unsigned MAX_TRACKS         = 256;

    // Configuration register addresses (byte address bit 2 selects register)
    localparam logic REG_TRACK_LENGTH = 1'b0;

endpackage

`default_nettype wire

[hdl/tracker_song_position_sequencer.sv]
// Song-position sequencer of a music tracker: tick counting, row and order-list
// advance, row effects, song-length capture. Depends on tsps_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | in        | in_valid / in_stall | command, effect_code, effect_value,
//          |           |                     | pattern_rows, target_track
//  out     | out       | out_valid/out_stall | row_due, current_row, current_track,
//          |           |                     | song_looped, song_frames
//  cfg     | in/out    | APB write/read      | track_length at byte address 0
//
// One item per cycle while out_stall is low: a transfer lands in the input register, and
// once the result register is free or being taken it updates the sequencer state and loads it.
// Reset (rst_n low, asynchronous) loads all state but the result data with its reset values; no clear pass.
// A stalled result holds the input register; in_stall rises only when both are full.
`default_nettype none

module tracker_song_position_sequencer
    import tsps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  effect_code,
    input  wire logic [7:0]  effect_value,
    input  wire logic [7:0]  pattern_rows,
    input  wire logic [7:0]  target_track,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             row_due,
    output logic [7:0]       current_row,
    output logic [7:0]       current_track,
    output logic             song_looped,
    output logic [31:0]      song_frames,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration
    logic [8:0] track_length_reg;

    // Input register
    logic       in_valid_reg;
    command_t   command_reg;
    logic [2:0] effect_code_reg;
    logic [7:0] effect_value_reg;
    logic [7:0] pattern_rows_reg;
    logic [7:0] target_track_reg;

    // Sequencer state
    logic [7:0]  ticks_per_row_reg, ticks_per_row_next;
    logic [7:0]  tick_left_reg, tick_left_next;
    logic [7:0]  row_position_reg, row_position_next;
    logic [7:0]  track_position_reg, track_position_next;
    logic [7:0]  loop_row_reg, loop_row_next;
    logic [7:0]  loop_left_reg, loop_left_next;
    logic [7:0]  row_delay_reg, row_delay_next;
    logic [7:0]  rows_latched_reg, rows_latched_next;
    logic [31:0] frame_count_reg, frame_count_next;
    logic        looped_flag_reg, looped_flag_next;
    logic        row_pending_reg, row_pending_next;
    logic [7:0]  row_captured_reg, row_captured_next;
    logic [31:0] song_length_reg, song_length_next;
    logic        due_next;

    // Result register
    logic        out_valid_reg;
    logic        row_due_reg;
    logic [7:0]  current_row_reg;
    logic [7:0]  current_track_reg;
    logic        song_looped_reg;
    logic [31:0] song_frames_reg;

    logic advance;
    logic in_take;
    logic cfg_write;

    // Working values for the update
    logic [8:0]  len_eff;
    logic [8:0]  track_inc;
    logic        track_wrap;
    logic [7:0]  track_stepped;
    logic        adv_en;
    logic [7:0]  adv_rows;
    logic [7:0]  row_inc;
    logic [7:0]  loop_dec;
    logic [15:0] delay_product;

    // Handshake: stage moves when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // APB port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TRACK_LENGTH) ? {23'd0, track_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_length_reg <= TRACK_LENGTH_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_TRACK_LENGTH))
        begin
            track_length_reg <= pwdata[8:0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take || advance)
        begin
            in_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg      <= CMD_TICK;
            effect_code_reg  <= 3'd0;
            effect_value_reg <= 8'd0;
            pattern_rows_reg <= 8'd0;
            target_track_reg <= 8'd0;
        end
        else if (in_take)
        begin
            command_reg      <= command_t'(command);
            effect_code_reg  <= effect_code;
            effect_value_reg <= effect_value;
            pattern_rows_reg <= pattern_rows;
            target_track_reg <= target_track;
        end
    end

    // Order-list step with wrap; lengths above the maximum act as the maximum
    always_comb
    begin
        len_eff       = (track_length_reg > 9'(MAX_TRACKS)) ? 9'(MAX_TRACKS)
                                                            : track_length_reg;
        track_inc     = {1'b0, track_position_reg} + 9'd1;
        track_wrap    = (track_inc >= len_eff);
        track_stepped = track_wrap ? 8'd0 : track_inc[7:0];
        delay_product = 16'(ticks_per_row_reg) * 16'(effect_value_reg);
        loop_dec      = loop_left_reg - 8'd1;
    end

    // Compute the next state for the item in the input register
    always_comb
    begin
        ticks_per_row_next  = ticks_per_row_reg;
        tick_left_next      = tick_left_reg;
        row_position_next   = row_position_reg;
        track_position_next = track_position_reg;
        loop_row_next       = loop_row_reg;
        loop_left_next      = loop_left_reg;
        row_delay_next      = row_delay_reg;
        rows_latched_next   = rows_latched_reg;
        frame_count_next    = frame_count_reg;
        looped_flag_next    = looped_flag_reg;
        row_pending_next    = row_pending_reg;
        row_captured_next   = row_captured_reg;
        song_length_next    = song_length_reg;
        due_next            = 1'b0;
        adv_en              = 1'b0;
        adv_rows            = pattern_rows_reg;
        row_inc             = 8'd0;

        unique case (command_reg)
            CMD_TICK:
            begin
                frame_count_next = frame_count_reg + 32'd1;
                if (!row_pending_reg)
                begin
                    tick_left_next = tick_left_reg - 8'd1;
                    if (tick_left_next == 8'd0)
                    begin
                        row_pending_next  = 1'b1;
                        rows_latched_next = pattern_rows_reg;
                        row_captured_next = row_position_reg;
                        row_delay_next    = 8'd0;
                        due_next          = 1'b1;
                    end
                    else
                    begin
                        adv_en   = (tick_left_next == 8'd1);
                        adv_rows = pattern_rows_reg;
                    end
                end
            end
            CMD_ROW_EFFECT:
            begin
                if (row_pending_reg)
                begin
                    // Apply the row effect; unknown codes are dropped
                    if (effect_code_reg == FX_SPEED)
                    begin
                        ticks_per_row_next = effect_value_reg;
                    end
                    else if (effect_code_reg == FX_JUMP)
                    begin
                        track_position_next = effect_value_reg;
                        row_position_next   = 8'd0;
                    end
                    else if (effect_code_reg == FX_BREAK)
                    begin
                        track_position_next = track_stepped;
                        row_position_next   = effect_value_reg;
                    end
                    else if (effect_code_reg == FX_LOOP_START)
                    begin
                        loop_row_next = row_captured_reg;
                    end
                    else if (effect_code_reg == FX_LOOP)
                    begin
                        if (loop_left_reg == 8'd0)
                        begin
                            loop_left_next    = effect_value_reg;
                            row_position_next = loop_row_reg;
                        end
                        else
                        begin
                            loop_left_next = loop_dec;
                            if (loop_dec != 8'd0)
                            begin
                                row_position_next = loop_row_reg;
                            end
                        end
                    end
                    else if (effect_code_reg == FX_PATT_DELAY)
                    begin
                        row_delay_next = delay_product[7:0];
                    end
                end
            end
            CMD_ROW_END:
            begin
                if (row_pending_reg)
                begin
                    row_pending_next = 1'b0;
                    tick_left_next   = ticks_per_row_reg + row_delay_reg;
                    row_delay_next   = 8'd0;
                    adv_en           = (tick_left_next == 8'd1);
                    adv_rows         = rows_latched_reg;
                end
            end
            CMD_GOTO:
            begin
                track_position_next = target_track_reg;
                row_position_next   = 8'd0;
                loop_row_next       = 8'd0;
                loop_left_next      = 8'd0;
                tick_left_next      = TICK_LEFT_RESET;
                row_delay_next      = 8'd0;
                row_pending_next    = 1'b0;
            end
        endcase

        // Advance the row; at the pattern end step the order list
        if (adv_en)
        begin
            row_inc           = row_position_reg + 8'd1;
            row_position_next = row_inc;
            if (row_inc >= adv_rows)
            begin
                row_position_next   = 8'd0;
                loop_row_next       = 8'd0;
                loop_left_next      = 8'd0;
                track_position_next = track_stepped;
                if (track_wrap)
                begin
                    song_length_next = frame_count_next;
                    frame_count_next = 32'd0;
                    looped_flag_next = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_row_reg  <= TICKS_PER_ROW_RESET;
            tick_left_reg      <= TICK_LEFT_RESET;
            row_position_reg   <= 8'd0;
            track_position_reg <= 8'd0;
            loop_row_reg       <= 8'd0;
            loop_left_reg      <= 8'd0;
            row_delay_reg      <= 8'd0;
            rows_latched_reg   <= 8'd0;
            frame_count_reg    <= 32'd0;
            looped_flag_reg    <= 1'b0;
            row_pending_reg    <= 1'b0;
            row_captured_reg   <= 8'd0;
            song_length_reg    <= 32'd0;
        end
        else if (advance)
        begin
            ticks_per_row_reg  <= ticks_per_row_next;
            tick_left_reg      <= tick_left_next;
            row_position_reg   <= row_position_next;
            track_position_reg <= track_position_next;
            loop_row_reg       <= loop_row_next;
            loop_left_reg      <= loop_left_next;
            row_delay_reg      <= row_delay_next;
            rows_latched_reg   <= rows_latched_next;
            frame_count_reg    <= frame_count_next;
            looped_flag_reg    <= looped_flag_next;
            row_pending_reg    <= row_pending_next;
            row_captured_reg   <= row_captured_next;
            song_length_reg    <= song_length_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_due_reg       <= due_next;
            current_row_reg   <= row_position_next;
            current_track_reg <= track_position_next;
            song_looped_reg   <= looped_flag_next;
            song_frames_reg   <= song_length_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_due       = row_due_reg;
    assign current_row   = current_row_reg;
    assign current_track = current_track_reg;
    assign song_looped   = song_looped_reg;
    assign song_frames   = song_frames_reg;

    // Checks
    a_due_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && row_due_reg |-> row_pending_reg)
        else $error("row_due shown without a pending row");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_looped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        looped_flag_reg |=> looped_flag_reg)
        else $error("looped flag cleared");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(row_position_reg) && $stable(track_position_reg))
        else $error("position changed without an item");

    a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> current_row_reg == row_position_reg
                    && current_track_reg == track_position_reg)
        else $error("result does not match updated state");

endmodule

`default_nettype wire

[test/song_position_checker.sv]
// Checker for the tracker song-position sequencer: watches both channels and the APB port,
// predicts each result from its own copy of the sequencer state and compares field by field.
// Depends on tsps_pkg.
module song_position_checker
    import tsps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  effect_code,
    input  wire logic [7:0]  effect_value,
    input  wire logic [7:0]  pattern_rows,
    input  wire logic [7:0]  target_track,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        row_due,
    input  wire logic [7:0]  current_row,
    input  wire logic [7:0]  current_track,
    input  wire logic        song_looped,
    input  wire logic [31:0] song_frames,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               open_results,
    output int               mismatches
);

    typedef struct packed {
        logic        row_due;
        logic [7:0]  row;
        logic [7:0]  track;
        logic        looped;
        logic [31:0] frames;
    } position_t;

    // predicted sequencer state
    logic [8:0]  order_len;
    logic [7:0]  speed_ticks;
    logic [7:0]  ticks_to_go;
    logic [7:0]  row_pos;
    logic [7:0]  order_pos;
    logic [7:0]  loop_anchor;
    logic [7:0]  loop_count;
    logic [7:0]  delay_ticks;
    logic [7:0]  due_rows;
    logic [7:0]  due_row;
    logic [31:0] frames_now;
    logic [31:0] last_pass_frames;
    logic        wrapped;
    logic        row_open;

    position_t expected_positions[$];
    int errors = 0;
    int waiting = 0;

    assign open_results = waiting;
    assign mismatches   = errors;

    // Step the order-list index; flag a wrap to the first entry.
    task automatic step_order(output logic wrap);
        logic [8:0] nxt;
        logic [8:0] lim;
        nxt = {1'b0, order_pos} + 9'd1;
        lim = (order_len > 9'd256) ? 9'd256 : order_len;
        wrap = (nxt >= lim);
        order_pos = wrap ? 8'd0 : nxt[7:0];
    endtask

    // Advance the row when one tick is left; end the pattern past its last row.
    task automatic advance_row(input logic [7:0] rows);
        logic wrap;
        if (ticks_to_go == 8'd1)
        begin
            row_pos = row_pos + 8'd1;
            if (row_pos >= rows)
            begin
                row_pos     = 8'd0;
                loop_anchor = 8'd0;
                loop_count  = 8'd0;
                step_order(wrap);
                if (wrap)
                begin
                    last_pass_frames = frames_now;
                    frames_now       = 32'd0;
                    wrapped          = 1'b1;
                end
            end
        end
    endtask

    task automatic apply_effect(input logic [2:0] code, input logic [7:0] value);
        logic [15:0] product;
        logic        wrap;
        case (code)
            FX_SPEED: speed_ticks = value;
            FX_JUMP:
            begin
                order_pos = value;
                row_pos   = 8'd0;
            end
            FX_BREAK:
            begin
                step_order(wrap);
                row_pos = value;
            end
            FX_LOOP_START: loop_anchor = due_row;
            FX_LOOP:
            begin
                if (loop_count == 8'd0)
                begin
                    loop_count = value;
                    row_pos    = loop_anchor;
                end
                else
                begin
                    loop_count = loop_count - 8'd1;
                    if (loop_count != 8'd0)
                        row_pos = loop_anchor;
                end
            end
            FX_PATT_DELAY:
            begin
                product     = 16'(speed_ticks) * 16'(value);
                delay_ticks = product[7:0];
            end
            default: ;
        endcase
    endtask

    // Run one input transfer through the predicted sequencer and build its result.
    task automatic play_item(input command_t cmd, input logic [2:0] code,
                             input logic [7:0] value, input logic [7:0] rows,
                             input logic [7:0] target, output position_t res);
        logic due;
        due = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                frames_now = frames_now + 32'd1;
                if (!row_open)
                begin
                    ticks_to_go = ticks_to_go - 8'd1;
                    if (ticks_to_go == 8'd0)
                    begin
                        row_open    = 1'b1;
                        due_rows    = rows;
                        due_row     = row_pos;
                        delay_ticks = 8'd0;
                        due         = 1'b1;
                    end
                    else
                        advance_row(rows);
                end
            end
            CMD_ROW_EFFECT:
            begin
                if (row_open)
                    apply_effect(code, value);
            end
            CMD_ROW_END:
            begin
                if (row_open)
                begin
                    row_open    = 1'b0;
                    ticks_to_go = speed_ticks + delay_ticks;
                    delay_ticks = 8'd0;
                    advance_row(due_rows);
                end
            end
            default:
            begin
                order_pos   = target;
                row_pos     = 8'd0;
                loop_anchor = 8'd0;
                loop_count  = 8'd0;
                ticks_to_go = TICK_LEFT_RESET;
                delay_ticks = 8'd0;
                row_open    = 1'b0;
            end
        endcase
        res.row_due = due;
        res.row     = row_pos;
        res.track   = order_pos;
        res.looped  = wrapped;
        res.frames  = last_pass_frames;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        position_t want;
        position_t got;
        if (!rst_n)
        begin
            order_len        = TRACK_LENGTH_RESET;
            speed_ticks      = TICKS_PER_ROW_RESET;
            ticks_to_go      = TICK_LEFT_RESET;
            row_pos          = 8'd0;
            order_pos        = 8'd0;
            loop_anchor      = 8'd0;
            loop_count       = 8'd0;
            delay_ticks      = 8'd0;
            due_rows         = 8'd0;
            due_row          = 8'd0;
            frames_now       = 32'd0;
            last_pass_frames = 32'd0;
            wrapped          = 1'b0;
            row_open         = 1'b0;
            expected_positions.delete();
            waiting = 0;
        end
        else
        begin
            // compare the result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.row_due = row_due;
                got.row     = current_row;
                got.track   = current_track;
                got.looped  = song_looped;
                got.frames  = song_frames;
                if (expected_positions.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: expected nothing, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_positions.pop_front();
                    check_field("row_due", 32'(want.row_due), 32'(got.row_due));
                    check_field("current_row", 32'(want.row), 32'(got.row));
                    check_field("current_track", 32'(want.track), 32'(got.track));
                    check_field("song_looped", 32'(want.looped), 32'(got.looped));
                    check_field("song_frames", want.frames, got.frames);
                end
            end

            // track register writes
            if (psel && penable && pwrite && pready && paddr[2] == REG_TRACK_LENGTH)
                order_len = pwdata[8:0];

            // predict the input transfer
            if (in_valid && !in_stall)
            begin
                play_item(command_t'(command), effect_code, effect_value, pattern_rows,
                          target_track, want);
                expected_positions.push_back(want);
            end
            waiting = expected_positions.size();
        end
    end

endmodule

[test/tb_tracker_song_position_sequencer.sv]
// Testbench top for the tracker song-position sequencer: drives row sequences, effects and
// register writes with random idling, and reports the verdict of song_position_checker.
// Depends on tsps_pkg, tracker_song_position_sequencer and song_position_checker.
module tb_tracker_song_position_sequencer;
    import tsps_pkg::*;

    localparam int         CYCLE_LIMIT       = 200000;
    localparam int         PHASE_ITEMS       = 130;
    localparam int         HOLD_CYCLES       = 80;
    localparam int         IDLE_PERCENT      = 37;
    localparam logic [2:0] TRACK_LENGTH_ADDR = {REG_TRACK_LENGTH, 2'b00};

    typedef struct packed {
        command_t   cmd;
        logic [2:0] code;
        logic [7:0] value;
        logic [7:0] rows;
        logic [7:0] target;
    } seq_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [2:0]  effect_code;
    logic [7:0]  effect_value;
    logic [7:0]  pattern_rows;
    logic [7:0]  target_track;
    logic        out_valid;
    logic        out_stall;
    logic        row_due;
    logic [7:0]  current_row;
    logic [7:0]  current_track;
    logic        song_looped;
    logic [31:0] song_frames;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int open_results;
    int mismatches;
    int cycles = 0;
    int hold_asked = 0;
    int hold_done = 0;
    logic steady = 1'b0;
    logic in_taken = 1'b0;
    seq_item_t item_q[$];

    tracker_song_position_sequencer DUT (.*);

    song_position_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Time out a hung run.
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        in_taken <= in_valid && !in_stall;

    // Offer queued items; hold a stalled transfer, idle at random between transfers.
    initial
    begin : drive_items
        seq_item_t it;
        in_valid     = 1'b0;
        command      = CMD_TICK;
        effect_code  = 3'd0;
        effect_value = 8'd0;
        pattern_rows = 8'd1;
        target_track = 8'd0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!in_valid || in_taken)
            begin
                if (item_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    it           = item_q.pop_front();
                    in_valid     = 1'b1;
                    command      = it.cmd;
                    effect_code  = it.code;
                    effect_value = it.value;
                    pattern_rows = it.rows;
                    target_track = it.target;
                end
                else
                    in_valid = 1'b0;
            end
        end
    end

    // Stall results at random; hold off for a long stretch on request.
    initial
    begin : drain_results
        int held;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_done != hold_asked)
            begin
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    out_stall = 1'b1;
                    @(negedge clk);
                    held++;
                end
                hold_done++;
            end
            out_stall = steady ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic push_item(input command_t cmd, input logic [2:0] code,
                             input logic [7:0] value, input logic [7:0] rows,
                             input logic [7:0] target);
        seq_item_t it;
        it.cmd    = cmd;
        it.code   = code;
        it.value  = value;
        it.rows   = rows;
        it.target = target;
        item_q.push_back(it);
    endtask

    // Pick a pattern length: mostly short, sometimes empty or anything.
    function automatic logic [7:0] pick_rows();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 8'($urandom_range(8, 1));
        else if (roll < 90)
            return 8'd0;
        return 8'($urandom);
    endfunction

    // Queue one row effect with a value that keeps the song moving.
    task automatic push_effect(input logic [7:0] rows);
        logic [2:0] code;
        logic [7:0] value;
        code = ($urandom_range(99) < 90) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
        value = 8'($urandom);
        case (code)
            FX_SPEED:      if ($urandom_range(99) < 97) value = 8'($urandom_range(3, 1));
            FX_JUMP:       if ($urandom_range(99) < 70) value = 8'($urandom_range(7));
            FX_BREAK:      if ($urandom_range(99) < 80) value = 8'($urandom_range(rows));
            FX_LOOP:       if ($urandom_range(99) < 85) value = 8'($urandom_range(3));
            FX_PATT_DELAY: if ($urandom_range(99) < 85) value = 8'($urandom_range(2));
            default: ;
        endcase
        push_item(CMD_ROW_EFFECT, code, value, 8'($urandom), 8'($urandom));
    endtask

    // Queue mostly whole rows (ticks, effects, row end) with some random noise.
    task automatic fill_phase(input int count);
        logic [7:0] pat;
        int         n_ticks;
        int         n_fx;
        pat = pick_rows();
        while (item_q.size() < count)
        begin
            if ($urandom_range(99) < 8)
                pat = pick_rows();
            if ($urandom_range(99) < 82)
            begin
                n_ticks = $urandom_range(4, 1);
                repeat (n_ticks)
                    push_item(CMD_TICK, 3'($urandom), 8'($urandom), pat, 8'($urandom));
                n_fx = $urandom_range(2);
                repeat (n_fx)
                    push_effect(pat);
                push_item(CMD_ROW_END, 3'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end
            else
                push_item(command_t'($urandom_range(3)), 3'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
        end
    endtask

    // Wait until every queued item is through and its result has arrived.
    task automatic settle();
        while (item_q.size() != 0 || in_valid || open_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_track_length(input logic [8:0] len);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = TRACK_LENGTH_ADDR;
        pwdata  = ($urandom & ~32'h1FF) | {23'd0, len};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin : run_song
        logic [8:0] lengths[8];
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 3'd0;
        pwdata  = 32'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // effects and row end with no row due, then rows that hit the edge cases
        push_item(CMD_ROW_EFFECT, FX_SPEED, 8'd3, 8'd4, 8'd0);
        push_item(CMD_ROW_END, 3'd0, 8'd0, 8'd4, 8'd0);
        push_item(CMD_TICK, 3'd0, 8'd0, 8'd4, 8'd0);
        push_item(CMD_TICK, 3'd7, 8'd255, 8'd4, 8'd255);
        push_item(CMD_ROW_EFFECT, FX_PATT_DELAY, 8'd255, 8'd4, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_SPEED, 8'd1, 8'd4, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_LOOP_START, 8'd0, 8'd4, 8'd0);
        push_item(CMD_ROW_EFFECT, 3'd6, 8'd12, 8'd4, 8'd0);
        push_item(CMD_ROW_EFFECT, 3'd7, 8'd99, 8'd4, 8'd0);
        push_item(CMD_ROW_END, 3'd0, 8'd0, 8'd4, 8'd0);
        push_item(CMD_GOTO, 3'd0, 8'd0, 8'd0, 8'd255);
        push_item(CMD_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_LOOP, 8'd2, 8'd0, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_LOOP, 8'd9, 8'd0, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_BREAK, 8'd255, 8'd0, 8'd0);
        push_item(CMD_ROW_END, 3'd0, 8'd0, 8'd0, 8'd0);
        push_item(CMD_TICK, 3'd0, 8'd0, 8'd255, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_JUMP, 8'd255, 8'd255, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_LOOP, 8'd0, 8'd255, 8'd0);
        push_item(CMD_ROW_END, 3'd0, 8'd0, 8'd255, 8'd0);
        push_item(CMD_TICK, 3'd0, 8'd0, 8'd255, 8'd0);
        push_item(CMD_ROW_EFFECT, FX_SPEED, 8'd0, 8'd255, 8'd0);
        push_item(CMD_ROW_END, 3'd0, 8'd0, 8'd255, 8'd0);
        push_item(CMD_TICK, 3'd0, 8'd0, 8'd255, 8'd0);
        push_item(CMD_GOTO, 3'd0, 8'd0, 8'd0, 8'd0);
        settle();

        // run through order-list lengths, extremes and out-of-range values among them
        lengths[0] = TRACK_LENGTH_RESET;
        lengths[1] = 9'd256;
        lengths[2] = 9'd2;
        lengths[3] = 9'd0;
        lengths[4] = 9'd511;
        lengths[5] = 9'($urandom_range(20, 3));
        lengths[6] = 9'd257;
        lengths[7] = 9'($urandom_range(256, 1));
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase != 0)
                write_track_length(lengths[phase]);
            steady = (phase == 1 || phase == 3);
            if (phase == 3)
                hold_asked++;
            fill_phase(PHASE_ITEMS);
            while (hold_done != hold_asked)
                @(negedge clk);
            settle();
            steady = 1'b0;
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[tracker_song_position_sequencer.f]
hdl/tsps_pkg.sv
hdl/tracker_song_position_sequencer.sv
test/song_position_checker.sv
test/tb_tracker_song_position_sequencer.sv
